@@ src/sdspi_pkg.sv @@
// ----------------------------------------------------------------------------
// sdspi_pkg
// shared types and constants of the spi-mode sd card slave
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int unsigned Blocks     = 64;
  localparam int unsigned BlkBytes   = 512;
  localparam int unsigned BlkW       = $clog2(Blocks);
  localparam int unsigned StoreAw    = $clog2(Blocks * BlkBytes);
  localparam int unsigned OffW       = $clog2(BlkBytes);

  localparam logic [7:0] ByteFf      = 8'hff;
  localparam logic [7:0] TokStart    = 8'hfe;
  localparam logic [7:0] Crc0        = 8'h95;
  localparam logic [7:0] DataAcc     = 8'h05;

  // command numbers
  localparam logic [5:0] CmdGoIdle  = 6'd0;
  localparam logic [5:0] CmdIfCond  = 6'd8;
  localparam logic [5:0] CmdRead    = 6'd17;
  localparam logic [5:0] CmdWrite   = 6'd24;
  localparam logic [5:0] CmdOpCond  = 6'd41;
  localparam logic [5:0] CmdAppCmd  = 6'd55;
  localparam logic [5:0] CmdReadOcr = 6'd58;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_READY    = 3'd1,
    PH_COMMAND  = 3'd2,
    PH_RESPONSE = 3'd3,
    PH_TOKEN    = 3'd4,
    PH_DATA     = 3'd5,
    PH_NONE     = 3'd7
  } phase_e;

  // response source selection
  typedef enum logic [3:0] {
    RS_NONE,
    RS_CMD0,
    RS_CMD8,
    RS_RD_START,
    RS_RD_DATA,
    RS_RD_CRC,
    RS_R1,
    RS_OCR,
    RS_WR_ACK
  } rsrc_e;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_FETCH,
    CTL_WAIT,
    CTL_OUT
  } ctl_e;

  typedef struct packed {
    logic       sel_chg;
    logic       sel_lvl;
    logic       cmd_shift;
    logic       cmd_done;
    logic       rd_req;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] miso;
    logic       busy;
  } dp_sts_t;

endpackage

@@ src/sd_card_spi_slave_top.sv @@
// ----------------------------------------------------------------------------
// sd_card_spi_slave_top
// spi-mode sd card slave, one miso byte per exchanged byte or select change
// ----------------------------------------------------------------------------
// usage:
// - input channel in_valid_i/in_ready_o carries kind_i, mosi_byte_i, select_i
// - output channel out_valid_o/out_ready_i carries miso_byte_o, one per input
// - cfg channel cfg_valid_i/cfg_ready_o writes block_count (reset 64)
// - the result is offered in the out state, after the fetch and wait
//   states that follow the input transfer and cover the registered store
//   read; the sequencer handles one item at a time
// - after a block write the 512-byte buffer is copied into the store,
//   and no input is taken during the copy
// - after reset the 32768-byte store is cleared one byte a cycle,
//   with in_ready_o low until the clear is done
// - while the receiver stalls the result is held and no input is taken
// ----------------------------------------------------------------------------
module sd_card_spi_slave_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [7:0] mosi_byte_i,
  input  logic       select_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] miso_byte_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i
);
  import sdspi_pkg::*;

  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [6:0] bc_q;
  logic [7:0] mosi_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= 7'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      bc_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) mosi_q <= mosi_byte_i;
  end

  sdspi_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .select_i,
    .out_valid_o, .out_ready_i, .sts_i(sts), .cmd_o(cmd)
  );

  sdspi_datapath u_dp (
    .clk_i, .rst_ni, .block_count_i(bc_q), .mosi_i(mosi_q),
    .cmd_i(cmd), .sts_o(sts)
  );

  assign miso_byte_o = sts.miso;
endmodule

@@ src/sdspi_datapath.sv @@
// ----------------------------------------------------------------------------
// sdspi_datapath
// card state, response sequencing and the block store
// ----------------------------------------------------------------------------
module sdspi_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [6:0]           block_count_i,
  input  logic [7:0]           mosi_i,
  input  sdspi_pkg::dp_cmd_t   cmd_i,
  output sdspi_pkg::dp_sts_t   sts_o
);
  import sdspi_pkg::*;

  // one-hot-free state
  phase_e      phase_q, phase_d, after_q, after_d;
  logic        sel_q, init_q, app_q;
  logic        sel_d, init_d, app_d;
  logic [47:0] cmdb_q, cmdb_d;
  logic [9:0]  cnt_q, cnt_d;
  logic [BlkW-1:0] tgt_q, tgt_d;
  rsrc_e       rs_q, rs_d;
  logic [9:0]  ridx_q, ridx_d;
  logic [7:0]  r1_q, r1_d, argb_q, argb_d;
  logic [7:0]  miso_q, miso_d;

  // memories
  logic [7:0]  store_mem [Blocks*BlkBytes];
  logic [7:0]  wbuf_mem  [BlkBytes];
  logic [7:0]  rd_q, wb_rd_q;

  // clearing / copy sweep
  logic              clr_q, cp_q, cp_ph_q;
  logic [StoreAw:0]  clr_cnt_q;
  logic [OffW:0]     cp_cnt_q;
  logic [OffW-1:0]   wb_raddr;
  logic              busy_sweep;

  logic [5:0]  num;
  logic [31:0] arg;
  logic [7:0]  crc;
  logic [47:0] cmdn;
  logic [6:0]  lim;
  logic        addr_ok;
  logic        rd_access;
  logic [StoreAw-1:0] rd_addr;
  logic [7:0]  rbyte;
  logic        last;
  logic        wr_byte;
  logic        wr_commit;

  assign busy_sweep = clr_q | cp_q;
  assign cmdn = {cmdb_q[39:0], mosi_i};
  assign num  = cmdn[45:40];
  assign arg  = cmdn[39:8];
  assign crc  = cmdn[7:0];
  assign lim  = (block_count_i < 7'(Blocks)) ? block_count_i : 7'(Blocks);
  assign addr_ok = (arg < {25'd0, lim});

  // data byte into the write buffer, commit on the last crc byte
  assign wr_byte   = cmd_i.cmd_shift && sel_q && (phase_q == PH_DATA);
  assign wr_commit = wr_byte && (cnt_q >= 10'(BlkBytes+1));

  // store read for block reads, address from target and index
  assign rd_access = cmd_i.rd_req;
  assign rd_addr   = {tgt_q, ridx_q[OffW-1:0]};
  assign wb_raddr  = cp_cnt_q[OffW-1:0];

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      store_mem[clr_cnt_q[StoreAw-1:0]] <= 8'h00;
    end else if (cp_q && cp_ph_q) begin
      store_mem[{tgt_q, cp_cnt_q[OffW-1:0] - OffW'(1)}] <= wb_rd_q;
    end
    rd_q <= store_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_byte && cnt_q < 10'(BlkBytes)) begin
      wbuf_mem[cnt_q[OffW-1:0]] <= mosi_i;
    end
    wb_rd_q <= wbuf_mem[wb_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      cp_q      <= 1'b0;
      cp_ph_q   <= 1'b0;
      cp_cnt_q  <= '0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == (StoreAw+1)'(Blocks*BlkBytes-1)) clr_q <= 1'b0;
      end
      if (wr_commit) begin
        cp_q     <= 1'b1;
        cp_ph_q  <= 1'b0;
        cp_cnt_q <= '0;
      end else if (cp_q) begin
        cp_ph_q  <= 1'b1;
        cp_cnt_q <= cp_cnt_q + 1'b1;
        if (cp_cnt_q == (OffW+1)'(BlkBytes)) cp_q <= 1'b0;
      end
    end
  end

  // response byte by source
  always_comb begin
    rbyte = ByteFf;
    last  = 1'b1;
    unique case (rs_q)
      RS_CMD0:     rbyte = r1_q;
      RS_R1:       rbyte = r1_q;
      RS_CMD8: begin
        last = (ridx_q == 10'd4);
        unique case (ridx_q[2:0])
          3'd0:    rbyte = 8'h01;
          3'd3:    rbyte = 8'h01;
          3'd4:    rbyte = argb_q;
          default: rbyte = 8'h00;
        endcase
      end
      RS_OCR: begin
        last = (ridx_q == 10'd4);
        unique case (ridx_q[2:0])
          3'd0:    rbyte = init_q ? 8'h00 : 8'h01;
          3'd1:    rbyte = init_q ? 8'hc0 : 8'h00;
          3'd2:    rbyte = ByteFf;
          3'd3:    rbyte = 8'h80;
          default: rbyte = 8'h00;
        endcase
      end
      RS_RD_START: begin
        last  = 1'b0;
        rbyte = ridx_q[0] ? TokStart : 8'h00;
      end
      RS_RD_DATA: begin
        last  = 1'b0;
        rbyte = rd_q;
      end
      RS_RD_CRC: begin
        last  = ridx_q[0];
        rbyte = 8'h00;
      end
      RS_WR_ACK: begin
        last  = ridx_q[0];
        rbyte = ridx_q[0] ? 8'h00 : DataAcc;
      end
      default: rbyte = ByteFf;
    endcase
  end

  always_comb begin
    phase_d = phase_q; after_d = after_q; sel_d = sel_q; init_d = init_q;
    app_d = app_q; cmdb_d = cmdb_q; cnt_d = cnt_q; tgt_d = tgt_q;
    rs_d = rs_q; ridx_d = ridx_q; r1_d = r1_q; argb_d = argb_q;
    miso_d = miso_q;
    if (cmd_i.sel_chg) begin
      miso_d = ByteFf;
      sel_d  = cmd_i.sel_lvl;
      if (cmd_i.sel_lvl) begin
        cnt_d = '0; cmdb_d = '0; rs_d = RS_NONE; ridx_d = '0;
        phase_d = PH_COMMAND;
      end else begin
        phase_d = init_q ? PH_READY : PH_IDLE;
      end
    end else if (cmd_i.cmd_shift) begin
      miso_d = ByteFf;
      if (sel_q) begin
        unique case (phase_q)
          PH_COMMAND: begin
            cmdb_d = cmdn;
            cnt_d  = cnt_q + 1'b1;
            if (cnt_q >= 10'd5) begin
              cnt_d   = '0;
              phase_d = PH_RESPONSE;
              ridx_d  = '0;
              rs_d    = RS_R1;
              argb_d  = arg[7:0];
              if (app_q) begin
                app_d = 1'b0;
                if (num == CmdOpCond) begin
                  init_d = 1'b1; r1_d = 8'h00;
                end else begin
                  r1_d = ByteFf;
                end
              end else begin
                unique case (num)
                  CmdGoIdle: begin
                    init_d = 1'b0;
                    r1_d = (crc != Crc0) ? 8'h09 : 8'h01;
                  end
                  CmdIfCond: rs_d = RS_CMD8;
                  CmdRead, CmdWrite: begin
                    if (!init_q) r1_d = 8'h05;
                    else if (!addr_ok) r1_d = 8'h40;
                    else if (num == CmdRead) begin
                      rs_d = RS_RD_START;
                      tgt_d = arg[BlkW-1:0];
                    end else begin
                      r1_d = 8'h00;
                      after_d = PH_TOKEN;
                      tgt_d = arg[BlkW-1:0];
                    end
                  end
                  CmdAppCmd: begin
                    r1_d = init_q ? 8'h00 : 8'h01;
                    app_d = 1'b1;
                  end
                  CmdReadOcr: rs_d = RS_OCR;
                  default: r1_d = init_q ? 8'h04 : 8'h05;
                endcase
              end
            end
          end
          PH_RESPONSE: begin
            if (rs_q != RS_NONE) begin
              miso_d = rbyte;
              ridx_d = ridx_q + 1'b1;
              if (rs_q == RS_RD_START && ridx_q[0]) begin
                rs_d = RS_RD_DATA; ridx_d = '0;
              end else if (rs_q == RS_RD_DATA && ridx_q == 10'(BlkBytes-1)) begin
                rs_d = RS_RD_CRC; ridx_d = '0;
              end else if (last) begin
                rs_d = RS_NONE; ridx_d = '0;
                if (after_q != PH_NONE) begin
                  phase_d = after_q; after_d = PH_NONE;
                end else begin
                  phase_d = PH_READY;
                end
              end
            end
          end
          PH_TOKEN: begin
            if (mosi_i == TokStart) begin
              cnt_d = '0; phase_d = PH_DATA;
            end
          end
          PH_DATA: begin
            cnt_d = cnt_q + 1'b1;
            if (cnt_q >= 10'(BlkBytes+1)) begin
              cnt_d = '0; phase_d = PH_RESPONSE;
              rs_d = RS_WR_ACK; ridx_d = '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; after_q <= PH_NONE; sel_q <= 1'b0; init_q <= 1'b0;
      app_q <= 1'b0; cmdb_q <= '0; cnt_q <= '0; tgt_q <= '0;
      rs_q <= RS_NONE; ridx_q <= '0; r1_q <= '0; argb_q <= '0;
      miso_q <= ByteFf;
    end else begin
      phase_q <= phase_d; after_q <= after_d; sel_q <= sel_d; init_q <= init_d;
      app_q <= app_d; cmdb_q <= cmdb_d; cnt_q <= cnt_d; tgt_q <= tgt_d;
      rs_q <= rs_d; ridx_q <= ridx_d; r1_q <= r1_d; argb_q <= argb_d;
      miso_q <= miso_d;
    end
  end

  assign sts_o.miso = miso_q;
  assign sts_o.busy = busy_sweep | rd_access;
endmodule

@@ src/sdspi_ctrl.sv @@
// ----------------------------------------------------------------------------
// sdspi_ctrl
// handshake sequencer: fetches store data, steps datapath, holds result
// ----------------------------------------------------------------------------
module sdspi_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic                select_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  sdspi_pkg::dp_sts_t  sts_i,
  output sdspi_pkg::dp_cmd_t  cmd_o
);
  import sdspi_pkg::*;

  ctl_e state_q, state_d;
  logic kind_q, sel_q, busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_IDLE;
      kind_q  <= 1'b0;
      sel_q   <= 1'b0;
      busy_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      busy_q  <= sts_i.busy;
      if (in_valid_i && in_ready_o) begin
        kind_q <= kind_i;
        sel_q  <= select_i;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CTL_IDLE:  if (in_valid_i && in_ready_o) state_d = CTL_FETCH;
      CTL_FETCH: state_d = CTL_WAIT;
      CTL_WAIT:  state_d = CTL_OUT;
      CTL_OUT:   if (out_ready_i) state_d = CTL_IDLE;
      default:   state_d = CTL_IDLE;
    endcase
  end

  // store data is read in fetch, registered by wait; datapath steps in wait
  always_comb begin
    in_ready_o  = (state_q == CTL_IDLE) && !sts_i.busy && !busy_q;
    out_valid_o = (state_q == CTL_OUT);
    cmd_o       = '0;
    cmd_o.rd_req = (state_q == CTL_FETCH);
    if (state_q == CTL_WAIT) begin
      cmd_o.sel_chg   = kind_q;
      cmd_o.sel_lvl   = sel_q;
      cmd_o.cmd_shift = !kind_q;
    end
  end
endmodule
